// ----- rtl/core/event_pixel_throttle_macros.svh -----
// ----------------------------------------------------------------------------
// event_pixel_throttle_macros.svh
// Assertion macros used by the event pixel throttle RTL.
// ----------------------------------------------------------------------------
`ifndef EVENT_PIXEL_THROTTLE_MACROS_SVH
`define EVENT_PIXEL_THROTTLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define EPT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("event_pixel_throttle: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define EPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("event_pixel_throttle: next-cycle check failed");

`endif

// ----- rtl/core/ept_pkg.sv -----
// ----------------------------------------------------------------------------
// ept_pkg
// Types and constants of the event pixel throttle.
// ----------------------------------------------------------------------------
package ept_pkg;

	// Grid and field widths
	localparam int NUM_PIXELS = 4096;
	localparam int PIX_W     = 12;
	localparam int STAMP_W   = 32;
	localparam int CNT_W     = 16;
	localparam int CTR_W     = 32;
	localparam int THR_W     = 16;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	// Only addresses a pixel field can reach need storage
	localparam int MEM_DEPTH = (NUM_PIXELS < (1 << PIX_W)) ? NUM_PIXELS : (1 << PIX_W);
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// Batch epoch tag kept with each entry
	localparam int EPOCH_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_RATE_THRESHOLD = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_MIN_GAP        = cfg_idx_t'(1);

	// One pixel entry
	typedef struct packed {
		logic               valid;
		logic [EPOCH_W-1:0] epoch;
		logic [CNT_W-1:0]   count;
		logic               dl_set;
		logic [STAMP_W-1:0] deadline;
	} pix_entry_t;

	// Memory write request
	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		pix_entry_t        data;
	} mem_wr_t;

	// Memory read request
	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
	} mem_rd_t;

endpackage

// ----- rtl/core/ept_pixel_mem.sv -----
// ----------------------------------------------------------------------------
// ept_pixel_mem
// Per-pixel state memory: one write and one registered read per cycle, with
// the write of the same edge forwarded into the read data.
// ----------------------------------------------------------------------------
module ept_pixel_mem (
	input  logic                clk,
	input  ept_pkg::mem_wr_t    wr,
	input  ept_pkg::mem_rd_t    rd,
	output ept_pkg::pix_entry_t rd_data
);
	import ept_pkg::*;

	pix_entry_t mem [MEM_DEPTH];
	pix_entry_t rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read port; a write to the same entry at this edge wins
	always_ff @(posedge clk) begin
		if (rd.en) begin
			if (wr.en && (wr.addr == rd.addr)) begin
				rd_data_q <= wr.data;
			end else begin
				rd_data_q <= mem[rd.addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/event_pixel_throttle.sv -----
// ----------------------------------------------------------------------------
// event_pixel_throttle
// Per-pixel rate and refractory filter for a pixel event stream.
// ----------------------------------------------------------------------------
// The block takes one event per cycle while evt_stall is low and gives one
// result per event: at acceptance the pixel entry is read from the state
// memory, in the update stage it is updated and written back, and the result
// goes into an output register. A back-to-back event on the same pixel gets
// the new entry by forwarding on the memory read port. A batch start forgets
// all pixels at once by moving to a new epoch. After reset the block clears
// the state memory before it takes the first event. At the 65536th batch
// start after reset, and at every 65535th one after that, it waits for the
// update stage to drain, which a stall on the result side holds up, and
// clears the memory again; configuration writes are taken throughout. Apart
// from these passes the rate is one event per cycle whenever the result side
// does not stall.
// ----------------------------------------------------------------------------
`include "event_pixel_throttle_macros.svh"

module event_pixel_throttle (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_write,
	input  ept_pkg::cfg_idx_t             cfg_index,
	input  logic [ept_pkg::CFG_W-1:0]     cfg_data,
	// event requests
	input  logic                          evt_valid,
	output logic                          evt_stall,
	input  logic [ept_pkg::PIX_W-1:0]     pixel,
	input  logic [ept_pkg::STAMP_W-1:0]   stamp,
	input  logic                          batch_start,
	// result requests
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          keep,
	output logic [ept_pkg::CTR_W-1:0]     event_index,
	output logic [ept_pkg::CTR_W-1:0]     kept_total
);
	import ept_pkg::*;

	localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
	localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
	localparam logic [STAMP_W-1:0] STAMP_MAX  = '1;

	// configuration registers
	logic [THR_W-1:0]   rate_threshold_q;
	logic [STAMP_W-1:0] min_gap_q;

	// control state
	logic               sweep_q;
	logic [MEM_AW-1:0]  sweep_addr_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [CTR_W-1:0]   seen_q;
	logic [CTR_W-1:0]   kept_q;

	// update stage
	logic               valid_s1;
	logic [MEM_AW-1:0]  addr_s1;
	logic               in_range_s1;
	logic [STAMP_W-1:0] stamp_s1;
	logic [EPOCH_W-1:0] epoch_s1;
	logic [CTR_W-1:0]   index_s1;

	// output register
	logic               res_valid_q;
	logic               keep_q;
	logic [CTR_W-1:0]   index_q;
	logic [CTR_W-1:0]   total_q;

	logic               evt_acc;
	logic               adv_s1;
	logic               wrap_req;
	logic [EPOCH_W-1:0] evt_epoch;
	mem_wr_t            mem_wr;
	mem_rd_t            mem_rd;
	pix_entry_t         rd_entry;
	pix_entry_t         new_entry;

	logic               hit;
	logic [CNT_W-1:0]   cnt_cur;
	logic [CNT_W-1:0]   cnt_inc;
	logic               has_dl;
	logic [STAMP_W:0]   dl_sum;
	logic [STAMP_W-1:0] dl_next;
	logic               keep_s1;

	// Configuration decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_threshold_q <= THR_W'(1);
			min_gap_q        <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_RATE_THRESHOLD: rate_threshold_q <= cfg_data[THR_W-1:0];
				CFG_MIN_GAP:        min_gap_q        <= cfg_data[STAMP_W-1:0];
				default:            ;
			endcase
		end
	end

	// Handshake: the update stage moves on when the output register is free
	assign adv_s1    = valid_s1 && (!res_valid_q || !res_stall);
	assign wrap_req  = evt_valid && batch_start && (epoch_q == EPOCH_LAST) && !sweep_q;
	assign evt_stall = sweep_q || wrap_req || (valid_s1 && !adv_s1);
	assign evt_acc   = evt_valid && !evt_stall;
	assign evt_epoch = batch_start ? (epoch_q + EPOCH_W'(1)) : epoch_q;

	// Memory read at acceptance
	assign mem_rd.en   = evt_acc;
	assign mem_rd.addr = pixel[MEM_AW-1:0];

	ept_pixel_mem u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd      (mem_rd),
		.rd_data (rd_entry)
	);

	// Update of the pixel entry
	always_comb begin
		hit     = rd_entry.valid && (rd_entry.epoch == epoch_s1);
		cnt_cur = hit ? rd_entry.count : '0;
		has_dl  = hit && rd_entry.dl_set;
		cnt_inc = (cnt_cur == CNT_MAX) ? cnt_cur : (cnt_cur + CNT_W'(1));
		dl_sum  = {1'b0, stamp_s1} + {1'b0, min_gap_q};
		dl_next = dl_sum[STAMP_W] ? STAMP_MAX : dl_sum[STAMP_W-1:0];
		keep_s1 = in_range_s1 && (cnt_inc >= rate_threshold_q)
			&& (!has_dl || (stamp_s1 >= rd_entry.deadline));

		new_entry.valid    = 1'b1;
		new_entry.epoch    = epoch_s1;
		new_entry.count    = keep_s1 ? '0 : cnt_inc;
		new_entry.dl_set   = keep_s1 || has_dl;
		new_entry.deadline = keep_s1 ? dl_next : rd_entry.deadline;
	end

	// Write port: clearing pass or write-back
	always_comb begin
		if (sweep_q) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = sweep_addr_q;
			mem_wr.data = '0;
		end else begin
			mem_wr.en   = adv_s1 && in_range_s1;
			mem_wr.addr = addr_s1;
			mem_wr.data = new_entry;
		end
	end

	// Clearing pass, epoch and event counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			epoch_q      <= '0;
			seen_q       <= '0;
			kept_q       <= '0;
		end else begin
			if (sweep_q) begin
				sweep_addr_q <= sweep_addr_q + MEM_AW'(1);
				if (sweep_addr_q == MEM_AW'(MEM_DEPTH - 1)) begin
					sweep_q <= 1'b0;
				end
			end else if (wrap_req && !valid_s1) begin
				sweep_q      <= 1'b1;
				sweep_addr_q <= '0;
				epoch_q      <= '0;
			end
			if (evt_acc) begin
				epoch_q <= evt_epoch;
				seen_q  <= seen_q + CTR_W'(1);
			end
			if (adv_s1 && keep_s1) begin
				kept_q <= kept_q + CTR_W'(1);
			end
		end
	end

	// Update stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Update stage payload
	always_ff @(posedge clk) begin
		if (evt_acc) begin
			addr_s1     <= pixel[MEM_AW-1:0];
			in_range_s1 <= (32'(pixel) < 32'(NUM_PIXELS));
			stamp_s1    <= stamp;
			epoch_s1    <= evt_epoch;
			index_s1    <= seen_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			keep_q  <= keep_s1;
			index_q <= index_s1;
			total_q <= kept_q + CTR_W'(keep_s1);
		end
	end

	assign res_valid   = res_valid_q;
	assign keep        = keep_q;
	assign event_index = index_q;
	assign kept_total  = total_q;

	// Checks
	`EPT_ASSERT_SAME(a_no_event_in_sweep, sweep_q, !evt_acc && !valid_s1)
	`EPT_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv_s1, valid_s1 && $stable(index_s1))
	`EPT_ASSERT_NEXT(a_kept_counts, adv_s1 && keep_s1, kept_q == $past(kept_q) + CTR_W'(1))
	`EPT_ASSERT_NEXT(a_index_follows, adv_s1 && valid_s1 && evt_acc,
		valid_s1 && (index_s1 == $past(index_s1) + CTR_W'(1)))

endmodule
